// ===== src/srp_pkg.sv =====
// Shared types and codes for the sensor record parser.
// No dependencies; imported by every module of the block.
package srp_pkg;

  localparam int unsigned QDepth = 3;
  localparam int unsigned QPtrW = 2;

  localparam logic [1:0] KIND_NAME = 2'd0;
  localparam logic [1:0] KIND_UNIT = 2'd1;
  localparam logic [1:0] KIND_REC  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TRUNC    = 2'd1;
  localparam logic [1:0] ST_TRAILING = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  char_byte;
    logic [31:0] record_handle;
    logic [15:0] sensor_ident;
    logic [7:0]  name_length;
    logic [7:0]  unit_length;
    logic [63:0] upper_raw;
    logic [63:0] lower_raw;
    logic [1:0]  status;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       first;
    res_t       second;
  } parse_out_t;

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    logic [QPtrW-1:0] r;
    if (p == QPtrW'(QDepth - 1)) r = '0;
    else r = p + QPtrW'(1);
    return r;
  endfunction

endpackage

// ===== src/srp_parse.sv =====
// Record field parser: phase state, field accumulators and result forming.
// Depends on srp_pkg.
module srp_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic [7:0]         in_byte,
  input  logic               frame_last,
  output srp_pkg::parse_out_t po
);
  import srp_pkg::*;

  localparam logic [3:0] PH_HANDLE  = 4'd0;
  localparam logic [3:0] PH_IDENT   = 4'd1;
  localparam logic [3:0] PH_NAMELEN = 4'd2;
  localparam logic [3:0] PH_NAME    = 4'd3;
  localparam logic [3:0] PH_UNITLEN = 4'd4;
  localparam logic [3:0] PH_UNIT    = 4'd5;
  localparam logic [3:0] PH_UPPER   = 4'd6;
  localparam logic [3:0] PH_LOWER   = 4'd7;
  localparam logic [3:0] PH_DONE    = 4'd8;

  logic [3:0]  phase_r, phase_nxt;
  logic [2:0]  bc_r, bc_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [31:0] handle_r, handle_nxt;
  logic [15:0] ident_r, ident_nxt;
  logic [7:0]  nlen_r, nlen_nxt;
  logic [7:0]  ulen_r, ulen_nxt;
  logic [63:0] upper_r, upper_nxt;
  logic [63:0] lower_r, lower_nxt;
  logic        trail_r, trail_nxt;
  res_t        ch;
  res_t        rec;
  logic        is_char;

  always_comb begin
    phase_nxt  = phase_r;
    bc_nxt     = bc_r;
    left_nxt   = left_r;
    handle_nxt = handle_r;
    ident_nxt  = ident_r;
    nlen_nxt   = nlen_r;
    ulen_nxt   = ulen_r;
    upper_nxt  = upper_r;
    lower_nxt  = lower_r;
    trail_nxt  = trail_r;
    ch         = '0;
    rec        = '0;
    is_char    = 1'b0;
    po         = '0;
    if (acc) begin
      unique case (phase_r)
        PH_HANDLE: begin
          handle_nxt[{bc_r[1:0], 3'b000} +: 8] = handle_r[{bc_r[1:0], 3'b000} +: 8] | in_byte;
          if (bc_r == 3'd3) begin
            bc_nxt    = '0;
            phase_nxt = PH_IDENT;
          end else begin
            bc_nxt = bc_r + 3'd1;
          end
        end
        PH_IDENT: begin
          ident_nxt[{bc_r[0], 3'b000} +: 8] = ident_r[{bc_r[0], 3'b000} +: 8] | in_byte;
          if (bc_r == 3'd1) begin
            bc_nxt    = '0;
            phase_nxt = PH_NAMELEN;
          end else begin
            bc_nxt = bc_r + 3'd1;
          end
        end
        PH_NAMELEN: begin
          nlen_nxt  = in_byte;
          left_nxt  = in_byte;
          phase_nxt = (in_byte == 8'd0) ? PH_UNITLEN : PH_NAME;
        end
        PH_NAME, PH_UNIT: begin
          is_char      = 1'b1;
          ch.kind      = (phase_r == PH_NAME) ? KIND_NAME : KIND_UNIT;
          ch.char_byte = in_byte;
          left_nxt     = left_r - 8'd1;
          if (left_r == 8'd1) begin
            phase_nxt = (phase_r == PH_NAME) ? PH_UNITLEN : PH_UPPER;
          end
        end
        PH_UNITLEN: begin
          ulen_nxt  = in_byte;
          left_nxt  = in_byte;
          phase_nxt = (in_byte == 8'd0) ? PH_UPPER : PH_UNIT;
        end
        PH_UPPER: begin
          upper_nxt[{bc_r, 3'b000} +: 8] = upper_r[{bc_r, 3'b000} +: 8] | in_byte;
          if (bc_r == 3'd7) phase_nxt = PH_LOWER;
          bc_nxt = bc_r + 3'd1;
        end
        PH_LOWER: begin
          lower_nxt[{bc_r, 3'b000} +: 8] = lower_r[{bc_r, 3'b000} +: 8] | in_byte;
          if (bc_r == 3'd7) phase_nxt = PH_DONE;
          bc_nxt = bc_r + 3'd1;
        end
        default: begin
          trail_nxt = 1'b1;
        end
      endcase

      rec.kind          = KIND_REC;
      rec.record_handle = handle_nxt;
      rec.sensor_ident  = ident_nxt;
      rec.name_length   = nlen_nxt;
      rec.unit_length   = ulen_nxt;
      rec.upper_raw     = upper_nxt;
      rec.lower_raw     = lower_nxt;
      if (trail_nxt) rec.status = ST_TRAILING;
      else if (phase_nxt >= PH_DONE) rec.status = ST_OK;
      else rec.status = ST_TRUNC;

      if (is_char) begin
        po.first  = ch;
        po.second = rec;
        po.cnt    = frame_last ? 2'd2 : 2'd1;
      end else begin
        po.first = rec;
        po.cnt   = frame_last ? 2'd1 : 2'd0;
      end

      if (frame_last) begin
        phase_nxt  = PH_HANDLE;
        bc_nxt     = '0;
        left_nxt   = '0;
        handle_nxt = '0;
        ident_nxt  = '0;
        nlen_nxt   = '0;
        ulen_nxt   = '0;
        upper_nxt  = '0;
        lower_nxt  = '0;
        trail_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HANDLE;
      bc_r     <= '0;
      left_r   <= '0;
      handle_r <= '0;
      ident_r  <= '0;
      nlen_r   <= '0;
      ulen_r   <= '0;
      upper_r  <= '0;
      lower_r  <= '0;
      trail_r  <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      bc_r     <= bc_nxt;
      left_r   <= left_nxt;
      handle_r <= handle_nxt;
      ident_r  <= ident_nxt;
      nlen_r   <= nlen_nxt;
      ulen_r   <= ulen_nxt;
      upper_r  <= upper_nxt;
      lower_r  <= lower_nxt;
      trail_r  <= trail_nxt;
    end
  end

endmodule

// ===== src/srp_outq.sv =====
// Three-entry result queue; takes up to two results per cycle, sends one.
// Depends on srp_pkg.
module srp_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  srp_pkg::parse_out_t po,
  output logic                space,
  output logic                q_valid,
  input  logic                q_pop,
  output srp_pkg::res_t       q_head
);
  import srp_pkg::*;

  res_t             mem_r [QDepth];
  logic [QPtrW-1:0] wr_r, wr_nxt;
  logic [QPtrW-1:0] rd_r, rd_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             pop;

  assign space   = (cnt_r <= 2'd1);
  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = mem_r[rd_r];
  assign pop     = q_pop && q_valid;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    if (po.cnt == 2'd1) wr_nxt = ptr_inc(wr_r);
    else if (po.cnt == 2'd2) wr_nxt = ptr_inc(ptr_inc(wr_r));
    if (pop) rd_nxt = ptr_inc(rd_r);
    cnt_nxt = cnt_r + po.cnt - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (po.cnt != 2'd0) mem_r[wr_r] <= po.first;
    if (po.cnt == 2'd2) mem_r[ptr_inc(wr_r)] <= po.second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== src/sensor_record_parser.sv =====
// Sensor descriptor record parser, top level.
// Depends on srp_pkg, srp_parse and srp_outq.
//
// Input stream: one frame byte per beat on in_tdata, in_tlast on the frame's
// final byte. Output stream: one result per beat; out_tuser gives the kind
// (name char, unit char, finished record) and out_tlast marks the record beat.
// A name or unit byte yields a character beat; the final byte also yields a
// record beat carrying handle, id, lengths, raw limit words and status.
// A byte's results are in the result queue the cycle after its beat is
// taken. Throughput: one byte per cycle while each byte gives at most one
// result and the receiver keeps up; a byte that is both a string character
// and the last byte gives two results, then in_tready drops. The three-entry
// queue sets this rate: in_tready is high while at most one result is queued.
// When the receiver stalls the queue fills and in_tready drops; nothing is
// lost. Reset clears the parser state and empties the queue; the block takes
// bytes from the first cycle after reset. Parser state returns to its reset
// values after every frame.
module sensor_record_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] in_byte
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [207:0] out_tdata,  // char_byte, record_handle, sensor_ident,
                                   // name_length, unit_length, upper_raw,
                                   // lower_raw, status, zero pad
  output logic [1:0]   out_tuser,  // [1:0] kind
  output logic         out_tlast
);
  import srp_pkg::*;

  parse_out_t po;
  res_t       head;
  logic       space;
  logic       in_acc;

  assign in_tready = space;
  assign in_acc    = in_tvalid && space;

  srp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (in_acc),
    .in_byte    (in_tdata),
    .frame_last (in_tlast),
    .po         (po)
  );

  srp_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .po      (po),
    .space   (space),
    .q_valid (out_tvalid),
    .q_pop   (out_tready),
    .q_head  (head)
  );

  assign out_tuser = head.kind;
  assign out_tlast = (head.kind == KIND_REC);
  assign out_tdata = {6'b0, head.status, head.lower_raw, head.upper_raw,
                      head.unit_length, head.name_length, head.sensor_ident,
                      head.record_handle, head.char_byte};

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> out_tvalid)
    else $error("frame end produced no result");

  a_stall_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty queue");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == KIND_NAME || out_tuser == KIND_UNIT ||
                    out_tuser == KIND_REC))
    else $error("illegal result kind");

endmodule
